### sv/quadratic_root_solver_defines.svh
// ----------------------------------------------------------------------------
// quadratic_root_solver_defines.svh
// Assertion macros shared by the solver's checker.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define QRS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define QRS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

### sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg
// Status codes shared by the solver modules and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

    // Kind of result carried with each item
    typedef enum logic [1:0] {
        ST_REAL    = 2'd0,
        ST_COMPLEX = 2'd1,
        ST_A_ZERO  = 2'd2,
        ST_R1_ZERO = 2'd3
    } t_status;

endpackage

`default_nettype wire

### sv/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider, one quotient bit per stage, signed saturated
// result. Magnitudes in, sign applied at the output.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div #(
    parameter int NW  = 48,
    parameter int DW  = 32,
    parameter int SBW = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_num,
    input  logic [DW-1:0]  i_den,
    input  logic           i_neg,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [DW-1:0]  o_res,
    output logic [SBW-1:0] o_sb
);

    logic           r_val [1:NW];
    logic [NW-1:0]  r_nq  [1:NW];
    logic [DW-1:0]  r_rem [1:NW];
    logic [DW-1:0]  r_den [1:NW];
    logic           r_neg [1:NW];
    logic [SBW-1:0] r_sb  [1:NW];

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic           v_i;
        logic [NW-1:0]  nq_i;
        logic [DW-1:0]  rem_i;
        logic [DW-1:0]  den_i;
        logic           neg_i;
        logic [SBW-1:0] sb_i;
        logic [DW:0]    t;
        logic [DW:0]    diff;
        logic           ge;
        logic [DW-1:0]  n_rem;

        if (k == 0) begin : g_in
            assign v_i   = i_valid;
            assign nq_i  = i_num;
            assign rem_i = '0;
            assign den_i = i_den;
            assign neg_i = i_neg;
            assign sb_i  = i_sb;
        end else begin : g_mid
            assign v_i   = r_val[k];
            assign nq_i  = r_nq[k];
            assign rem_i = r_rem[k];
            assign den_i = r_den[k];
            assign neg_i = r_neg[k];
            assign sb_i  = r_sb[k];
        end

        // Bring down the next numerator bit and try the subtraction
        assign t     = {rem_i, nq_i[NW-1]};
        assign diff  = t - {1'b0, den_i};
        assign ge    = (t >= {1'b0, den_i});
        assign n_rem = ge ? diff[DW-1:0] : t[DW-1:0];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k+1] <= 1'b0;
            end else if (i_en) begin
                r_val[k+1] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_nq[k+1]  <= {nq_i[NW-2:0], ge};
                r_rem[k+1] <= n_rem;
                r_den[k+1] <= den_i;
                r_neg[k+1] <= neg_i;
                r_sb[k+1]  <= sb_i;
            end
        end
    end

    // Apply sign and saturate to the signed result range
    logic [NW-1:0] q;
    logic [DW-1:0] q_neg;
    logic          hi_nz;
    logic          pos_ovf;
    logic          neg_ovf;

    assign q       = r_nq[NW];
    assign q_neg   = ~q[DW-1:0] + 1'b1;
    assign hi_nz   = |q[NW-1:DW];
    assign pos_ovf = hi_nz || q[DW-1];
    assign neg_ovf = hi_nz || (q[DW-1] && (|q[DW-2:0]));

    always_comb begin
        if (r_neg[NW]) begin
            o_res = neg_ovf ? {1'b1, {(DW-1){1'b0}}} : q_neg;
        end else begin
            o_res = pos_ovf ? {1'b0, {(DW-1){1'b1}}} : q[DW-1:0];
        end
    end

    assign o_valid = r_val[NW];
    assign o_sb    = r_sb[NW];

endmodule

`default_nettype wire

### sv/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt #(
    parameter int SW  = 50,
    parameter int SBW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [SW-1:0]   i_rad,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_valid,
    output logic [SW/2-1:0] o_root,
    output logic [SBW-1:0]  o_sb
);

    localparam int SH = SW / 2;
    localparam int RW = SH + 3;

    logic           r_val  [1:SH];
    logic [SW-1:0]  r_rad  [1:SH];
    logic [RW-1:0]  r_rem  [1:SH];
    logic [SH-1:0]  r_root [1:SH];
    logic [SBW-1:0] r_sb   [1:SH];

    for (genvar k = 0; k < SH; k++) begin : g_st
        logic           v_i;
        logic [SW-1:0]  rad_i;
        logic [RW-1:0]  rem_i;
        logic [SH-1:0]  root_i;
        logic [SBW-1:0] sb_i;
        logic [RW-1:0]  t;
        logic [RW-1:0]  trial;
        logic           ge;

        if (k == 0) begin : g_in
            assign v_i    = i_valid;
            assign rad_i  = i_rad;
            assign rem_i  = '0;
            assign root_i = '0;
            assign sb_i   = i_sb;
        end else begin : g_mid
            assign v_i    = r_val[k];
            assign rad_i  = r_rad[k];
            assign rem_i  = r_rem[k];
            assign root_i = r_root[k];
            assign sb_i   = r_sb[k];
        end

        // Bring down two radicand bits and test root*4+1
        assign t     = {rem_i[RW-3:0], rad_i[SW-1:SW-2]};
        assign trial = RW'({root_i, 2'b01});
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k+1] <= 1'b0;
            end else if (i_en) begin
                r_val[k+1] <= v_i;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k+1]  <= {rad_i[SW-3:0], 2'b00};
                r_rem[k+1]  <= ge ? (t - trial) : t;
                r_root[k+1] <= {root_i[SH-2:0], ge};
                r_sb[k+1]   <= sb_i;
            end
        end
    end

    assign o_valid = r_val[SH];
    assign o_root  = r_root[SH];
    assign o_sb    = r_sb[SH];

endmodule

`default_nettype wire

### sv/qrs_fifo.sv
// ----------------------------------------------------------------------------
// qrs_fifo
// Short queue between the divide front and the root back end.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_fifo #(
    parameter int WIDTH = 96,
    parameter int AW    = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_nempty,
    output logic [WIDTH-1:0] o_data
);

    localparam int DEPTH = 2 ** AW;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [AW:0]      r_cnt;

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full   = (r_cnt == (AW+1)'(DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_data   = r_mem[r_rp];

endmodule

`default_nettype wire

### sv/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front
// Accept coefficient items, flag a zero leading coefficient and normalize
// b and c by a in two parallel divide pipelines.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_c,
    input  logic [W-2:0] i_sq,
    output logic         o_ready,
    input  logic         i_full,
    output logic         o_valid,
    output logic [3*W-1:0] o_data
);

    logic         en;
    logic [W-1:0] a_mag;
    logic [W-1:0] b_mag;
    logic [W-1:0] c_mag;
    logic         b_valid;
    logic         c_valid;
    logic [W-1:0] nb;
    logic [W-1:0] nc;
    logic         az;
    logic [W-2:0] sq;

    // Stall the divide pipes only when the queue refuses the finished item
    assign en      = !b_valid || !i_full;
    assign o_ready = en;
    assign o_valid = b_valid && c_valid;

    assign a_mag = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign b_mag = i_b[W-1] ? (~i_b + 1'b1) : i_b;
    assign c_mag = i_c[W-1] ? (~i_c + 1'b1) : i_c;

    qrs_div #(.NW(W+F), .DW(W), .SBW(1)) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_num   ({b_mag, {F{1'b0}}}),
        .i_den   (a_mag),
        .i_neg   (i_a[W-1] ^ i_b[W-1]),
        .i_sb    (i_a == '0),
        .o_valid (b_valid),
        .o_res   (nb),
        .o_sb    (az)
    );

    qrs_div #(.NW(W+F), .DW(W), .SBW(W-1)) u_div_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_num   ({c_mag, {F{1'b0}}}),
        .i_den   (a_mag),
        .i_neg   (i_a[W-1] ^ i_c[W-1]),
        .i_sb    (i_sq),
        .o_valid (c_valid),
        .o_res   (nc),
        .o_sb    (sq)
    );

    assign o_data = {az, sq, nc, nb};

endmodule

`default_nettype wire

### sv/qrs_back.sv
// ----------------------------------------------------------------------------
// qrs_back
// Form the discriminant, take its root, pick the stable first root or the
// complex pair, divide for the second root and hold the result for output.
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [3*W-1:0] i_data,
    output logic           o_pop,
    input  logic           i_ready,
    output logic           o_valid,
    output logic [4*W-1:0] o_data,
    output logic [1:0]     o_status
);

    import qrs_pkg::*;

    localparam int SW0 = W + F + 2;
    localparam int SW  = SW0 + (SW0 % 2);
    localparam int SH  = SW / 2;
    localparam int CW  = ((SH > W) ? SH : W) + 1;
    localparam int TW  = CW + 1;
    localparam int SBW = 2 * W + 2;
    localparam int DBW = 4 * W + 2;

    logic en;

    // ---- discriminant stage ----
    logic [W-1:0] f_nb;
    logic [W-1:0] f_nc;
    logic [W-2:0] f_sq;
    logic         f_az;
    logic [W+2:0] disc;
    logic [W+2:0] disc_neg;

    logic         r0_valid;
    logic [W+1:0] r0_mag;
    logic         r0_dneg;
    logic [W-1:0] r0_nb;
    logic [W-1:0] r0_nc;
    logic         r0_az;

    assign en    = !o_valid || i_ready;
    assign o_pop = en && i_valid;

    assign f_nb     = i_data[W-1:0];
    assign f_nc     = i_data[2*W-1:W];
    assign f_sq     = i_data[3*W-2:2*W];
    assign f_az     = i_data[3*W-1];
    assign disc     = (W+3)'(f_sq) - {f_nc[W-1], f_nc, 2'b00};
    assign disc_neg = ~disc + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else if (en) begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_mag  <= disc[W+2] ? disc_neg[W+1:0] : disc[W+1:0];
            r0_dneg <= disc[W+2];
            r0_nb   <= f_nb;
            r0_nc   <= f_nc;
            r0_az   <= f_az;
        end
    end

    // ---- square root ----
    logic          sq_valid;
    logic [SH-1:0] root;
    logic [SBW-1:0] sq_sb;

    qrs_sqrt #(.SW(SW), .SBW(SBW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r0_valid),
        .i_rad   (SW'({r0_mag, {F{1'b0}}})),
        .i_sb    ({r0_az, r0_dneg, r0_nc, r0_nb}),
        .o_valid (sq_valid),
        .o_root  (root),
        .o_sb    (sq_sb)
    );

    // ---- root selection ----
    logic [W-1:0]  s_nb;
    logic [W-1:0]  s_nc;
    logic          s_dneg;
    logic          s_az;
    logic [SH-1:0] im_full;
    logic [CW-1:0] im_ext;
    logic [CW-1:0] smax_ext;
    logic [W-1:0]  im;
    logic [W-1:0]  im_neg;
    logic [W:0]    nb_negx;
    logic [W:0]    re_half;
    logic [TW-1:0] nbx;
    logic [TW-1:0] rtx;
    logic [TW-1:0] t;
    logic [TW-1:0] t_adj;
    logic [TW-1:0] t_half;
    logic          nb_pos;
    logic          ovf;
    logic [W-1:0]  s1;
    t_status       n_status;

    assign s_nb   = sq_sb[W-1:0];
    assign s_nc   = sq_sb[2*W-1:W];
    assign s_dneg = sq_sb[2*W];
    assign s_az   = sq_sb[2*W+1];

    // Complex pair: imaginary half-root, real part -nb/2 toward zero
    assign im_full  = root >> 1;
    assign im_ext   = CW'(im_full);
    assign smax_ext = CW'({1'b0, {(W-1){1'b1}}});
    assign im       = (im_ext > smax_ext) ? {1'b0, {(W-1){1'b1}}} : im_ext[W-1:0];
    assign im_neg   = ~im + 1'b1;
    assign nb_negx  = ~{s_nb[W-1], s_nb} + 1'b1;
    assign re_half  = (nb_negx + (W+1)'(nb_negx[W])) >> 1;

    // Stable real root, halved toward zero and saturated
    assign nbx    = TW'($signed(s_nb));
    assign rtx    = TW'(root);
    assign nb_pos = !s_nb[W-1] && (s_nb != '0);
    assign t      = nb_pos ? (-nbx - rtx) : (-nbx + rtx);
    assign t_adj  = t + TW'(t[TW-1]);
    assign t_half = {t_adj[TW-1], t_adj[TW-1:1]};
    assign ovf    = !((&t_half[TW-1:W-1]) || !(|t_half[TW-1:W-1]));
    assign s1     = ovf ? (t_half[TW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}})
                        : t_half[W-1:0];

    always_comb begin
        if (s_az) begin
            n_status = ST_A_ZERO;
        end else if (s_dneg) begin
            n_status = ST_COMPLEX;
        end else if (s1 == '0) begin
            n_status = ST_R1_ZERO;
        end else begin
            n_status = ST_REAL;
        end
    end

    logic         rs_valid;
    logic [W-1:0] rs_r1r;
    logic [W-1:0] rs_r1i;
    logic [W-1:0] rs_r2r;
    logic [W-1:0] rs_r2i;
    logic [W-1:0] rs_nc;
    logic [W-1:0] rs_s1;
    t_status      rs_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rs_valid <= 1'b0;
        end else if (en) begin
            rs_valid <= sq_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            rs_status <= n_status;
            rs_nc     <= s_nc;
            rs_s1     <= s1;
            case (n_status)
                ST_COMPLEX: begin
                    rs_r1r <= re_half[W-1:0];
                    rs_r1i <= im;
                    rs_r2r <= re_half[W-1:0];
                    rs_r2i <= im_neg;
                end
                ST_REAL: begin
                    rs_r1r <= s1;
                    rs_r1i <= '0;
                    rs_r2r <= '0;
                    rs_r2i <= '0;
                end
                default: begin
                    rs_r1r <= '0;
                    rs_r1i <= '0;
                    rs_r2r <= '0;
                    rs_r2i <= '0;
                end
            endcase
        end
    end

    // ---- second root divide ----
    logic [W-1:0]   nc_mag;
    logic [W-1:0]   s1_mag;
    logic           dv_valid;
    logic [W-1:0]   quo;
    logic [DBW-1:0] dv_sb;
    t_status        d_status;

    assign nc_mag = rs_nc[W-1] ? (~rs_nc + 1'b1) : rs_nc;
    assign s1_mag = rs_s1[W-1] ? (~rs_s1 + 1'b1) : rs_s1;

    qrs_div #(.NW(W+F), .DW(W), .SBW(DBW)) u_div_r2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (rs_valid),
        .i_num   ({nc_mag, {F{1'b0}}}),
        .i_den   (s1_mag),
        .i_neg   (rs_nc[W-1] ^ rs_s1[W-1]),
        .i_sb    ({rs_status, rs_r2i, rs_r2r, rs_r1i, rs_r1r}),
        .o_valid (dv_valid),
        .o_res   (quo),
        .o_sb    (dv_sb)
    );

    assign d_status = t_status'(dv_sb[DBW-1:DBW-2]);

    // ---- output register ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (en) begin
            o_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_status <= d_status;
            o_data   <= {dv_sb[4*W-1:3*W],
                         (d_status == ST_REAL) ? quo : dv_sb[3*W-1:2*W],
                         dv_sb[2*W-1:0]};
        end
    end

endmodule

`default_nettype wire

### sv/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Fixed-point roots of a*x^2 + b*x + c, one coefficient set per item.
// ----------------------------------------------------------------------------
// The block takes one item per clock while s_axis_tready is high and
// returns one result per item, in order. An item passes the bit-per-stage
// b/a and c/a divide pipelines, the discriminant register, the bit-per-stage
// square-root pipeline on an SW-bit radicand (DATA_WIDTH+FRAC_BITS+2 rounded
// up to even, 50 bits at Q16.16), the root-selection register, the c/r1
// divide pipeline and the output register. A four-entry queue sits between
// the divide front and the root back end, so while a result waits the input
// keeps taking items until the queue fills. tuser carries the status: real
// roots, complex pair, zero a, or zero first root.
`default_nettype none

module quadratic_root_solver #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // coef_a, coef_b, coef_c, norm_b_squared, zero pad
    input  logic [((4*DATA_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // root1_real, root1_imag, root2_real, root2_imag, zero pad
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [1:0] m_axis_tuser
);

    localparam int W      = DATA_WIDTH;
    localparam int OUT_TW = ((4*W+7)/8)*8;

    logic           fr_valid;
    logic [3*W-1:0] fr_data;
    logic           q_full;
    logic           q_nempty;
    logic [3*W-1:0] q_data;
    logic           q_pop;
    logic [4*W-1:0] bk_data;

    qrs_front #(.W(W), .F(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_a     (s_axis_tdata[W-1:0]),
        .i_b     (s_axis_tdata[2*W-1:W]),
        .i_c     (s_axis_tdata[3*W-1:2*W]),
        .i_sq    (s_axis_tdata[4*W-2:3*W]),
        .o_ready (s_axis_tready),
        .i_full  (q_full),
        .o_valid (fr_valid),
        .o_data  (fr_data)
    );

    qrs_fifo #(.WIDTH(3*W), .AW(2)) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (fr_valid && !q_full),
        .i_data   (fr_data),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_nempty (q_nempty),
        .o_data   (q_data)
    );

    qrs_back #(.W(W), .F(FRAC_BITS)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_nempty),
        .i_data   (q_data),
        .o_pop    (q_pop),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_data   (bk_data),
        .o_status (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_TW'(bk_data);

endmodule

`default_nettype wire

### sv/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_port_checks
// Port-level checks on the solver's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadratic_root_solver_defines.svh"

module qrs_port_checks #(
    parameter int DATA_WIDTH = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    input logic m_axis_tvalid,
    input logic m_axis_tready,
    input logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0] m_axis_tuser
);

    import qrs_pkg::*;

    localparam int W = DATA_WIDTH;

    logic [W-1:0] r1r;
    logic [W-1:0] r1i;
    logic [W-1:0] r2r;
    logic [W-1:0] r2i;
    logic         all_zero;
    logic         stalled;
    logic         conj_ok;
    logic         is_azero;
    logic         is_r1zero;
    logic         is_cplx;

    assign r1r       = m_axis_tdata[W-1:0];
    assign r1i       = m_axis_tdata[2*W-1:W];
    assign r2r       = m_axis_tdata[3*W-1:2*W];
    assign r2i       = m_axis_tdata[4*W-1:3*W];
    assign all_zero  = (r1r == '0) && (r1i == '0) && (r2r == '0) && (r2i == '0);
    assign stalled   = m_axis_tvalid && !m_axis_tready;
    assign conj_ok   = (r1r == r2r) && (W'(r1i + r2i) == '0);
    assign is_azero  = m_axis_tvalid && (m_axis_tuser == ST_A_ZERO);
    assign is_r1zero = m_axis_tvalid && (m_axis_tuser == ST_R1_ZERO);
    assign is_cplx   = m_axis_tvalid && (m_axis_tuser == ST_COMPLEX);

    `QRS_ASSERT_ALWAYS(a_rst_clears, !i_rst_n |=> !m_axis_tvalid, "valid after reset")
    `QRS_ASSERT(a_hold, stalled |=> m_axis_tvalid && $stable(m_axis_tdata), "result changed")
    `QRS_ASSERT(a_azero, is_azero |-> all_zero, "zero a gave roots")
    `QRS_ASSERT(a_r1zero, is_r1zero |-> all_zero, "zero root gave values")
    `QRS_ASSERT(a_conj, is_cplx |-> conj_ok, "pair not conjugate")

endmodule

bind quadratic_root_solver qrs_port_checks #(.DATA_WIDTH(DATA_WIDTH)) u_qrs_checker (.*);

`default_nettype wire
